// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants
// Operation and status codes, entry layout and default sizes for the queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned ENTRY_W      = DATA_W + PRIO_W;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/core/spq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram: generic single-port-write, single-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue, FIFO within a priority
// Sorted array in one RAM; insert and remove shift entries one at a time.
// ----------------------------------------------------------------------------
// Overflow, empty and unused-op beats go straight to the result; peek reads
// the head; dequeue reads the head, then moves the rest down, one move a cycle.
// Enqueue scans down from the tail with a read and a compare per entry moved
// up, then writes the new item; into an empty queue it writes slot 0 directly.
// One operation in flight; the next beat is taken the cycle after the result leaves.
// Reset clears the item count and control state; RAM contents stay undefined
// and entries beyond the count are never used.
module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic signed [spq_pkg::DATA_W-1:0] item_data,
  input  logic [spq_pkg::PRIO_W-1:0]    item_priority,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic signed [spq_pkg::DATA_W-1:0] head_data,
  output logic [spq_pkg::PRIO_W-1:0]    head_priority
);

  import spq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Enqueue: scan down from the tail, moving each larger entry up by one,
  // until an entry with priority not larger is found; write the new item
  // above it, or at slot 0 once the scan runs out. Dequeue: read head, then
  // move entries 1..n-1 down by one.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HREAD = 7'b0000010,
    S_HDONE = 7'b0000100,
    S_EREAD = 7'b0001000,
    S_ECMP  = 7'b0010000,
    S_DMOVE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;        // scan / move position
  logic [1:0] cur_op;
  logic [DATA_W-1:0] cur_data;
  logic [PRIO_W-1:0] cur_prio;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  spq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  // RAM drive
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        raddr = '0;
      end
      S_EREAD: begin
        raddr = AW'(idx - 1'b1);
      end
      S_ECMP: begin
        // rdata holds entry idx-1 unless the scan has reached slot 0
        we    = 1'b1;
        waddr = AW'(idx);
        if (idx != '0 && rdata[PRIO_W-1:0] > cur_prio) begin
          wdata = rdata;
          raddr = AW'(idx - 2'd2);
        end else begin
          wdata = {cur_data, cur_prio};
        end
      end
      S_HREAD: begin
        raddr = AW'(idx);
      end
      S_HDONE: begin
        raddr = AW'(idx);
      end
      S_DMOVE: begin
        // rdata holds entry idx; move it to idx-1
        we    = 1'b1;
        waddr = AW'(idx - 1'b1);
        wdata = rdata;
        raddr = AW'(idx + 1'b1);
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_op   <= op;
            cur_data <= item_data;
            cur_prio <= item_priority;
            unique case (op_t'(op))
              OP_ENQ: begin
                if (count >= CAP_C) begin
                  status <= ST_OVF; head_data <= '0; head_priority <= '0;
                  state  <= S_OUT;
                end else if (count == '0) begin
                  // write at slot 0 directly
                  idx   <= '0;
                  state <= S_ECMP;
                end else begin
                  idx   <= count;
                  state <= S_EREAD;
                end
              end
              OP_DEQ, OP_PEEK: begin
                if (count == '0) begin
                  status <= ST_EMPTY; head_data <= '0; head_priority <= '0;
                  state  <= S_OUT;
                end else begin
                  idx   <= '0;
                  state <= S_HREAD;
                end
              end
              default: begin
                status <= ST_OK; head_data <= '0; head_priority <= '0;
                state  <= S_OUT;
              end
            endcase
          end
        end
        S_HREAD: begin
          // head read issued in IDLE lands now
          head_data     <= rdata[ENTRY_W-1:PRIO_W];
          head_priority <= rdata[PRIO_W-1:0];
          status        <= ST_OK;
          if (cur_op == OP_DEQ && count > CW'(1)) begin
            idx   <= CW'(1);
            state <= S_HDONE;
          end else begin
            if (cur_op == OP_DEQ) count <= count - 1'b1;
            state <= S_OUT;
          end
        end
        S_HDONE: begin
          state <= S_DMOVE;
        end
        S_DMOVE: begin
          if (idx + 1'b1 >= count) begin
            count <= count - 1'b1;
            state <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EREAD: begin
          state <= S_ECMP;
        end
        S_ECMP: begin
          if (idx > CW'(1) && rdata[PRIO_W-1:0] > cur_prio) begin
            idx   <= idx - 1'b1;
            state <= S_EREAD;
          end else if (idx == CW'(1) && rdata[PRIO_W-1:0] > cur_prio) begin
            // entry 0 moved up; place new item at slot 0
            idx <= '0;
          end else begin
            count  <= count + 1'b1;
            status <= ST_OK; head_data <= '0; head_priority <= '0;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
